@@ design/sha512_pkg.sv @@
// Package: SHA-512 constants, types and round functions.
package sha512_pkg;
    typedef logic [63:0] t_word;

    localparam int unsigned WORDS_PER_BLOCK = 16;
    localparam int unsigned ROUND_COUNT     = 80;
    localparam logic [3:0]  LENGTH_SLOT     = 4'd14;
    localparam logic [3:0]  FULL_BYTES      = 4'd8;
    localparam t_word       PAD_WORD        = 64'h8000000000000000;

    localparam t_word ROUND_CONST [ROUND_COUNT] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam t_word INITIAL_VALUE [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word a);
        return rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
    endfunction

    function automatic t_word big_sigma1(input t_word e);
        return rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
    endfunction

    function automatic t_word small_sigma0(input t_word w);
        return rotr(w, 1) ^ rotr(w, 8) ^ (w >> 7);
    endfunction

    function automatic t_word small_sigma1(input t_word w);
        return rotr(w, 19) ^ rotr(w, 61) ^ (w >> 6);
    endfunction
endpackage

@@ design/sha512_stream_if.sv @@
// Interface: valid/ready stream channel with a generic payload.
interface sha512_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/sha512_core.sv @@
// Module: SHA-512 compression core, one round per cycle over a 16-word window.
module sha512_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_init,
    input  sha512_pkg::t_word   i_block [16],
    output logic                o_busy,
    output sha512_pkg::t_word   o_hash [8]
);
    import sha512_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_ADD} t_state;

    t_state      r_state;
    logic [6:0]  r_round;
    t_word       r_w [16];
    t_word       r_v [8];
    t_word       r_h [8];
    t_word       t1, t2, w_new;
    t_word       w_cur;

    assign w_cur = r_w[0];
    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + ROUND_CONST[r_round] + w_cur;
    assign t2 = big_sigma0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_new = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];

    assign o_busy = (r_state != S_IDLE);
    assign o_hash = r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_h     <= INITIAL_VALUE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_init) begin
                        r_h <= INITIAL_VALUE;
                    end else if (i_start) begin
                        r_w     <= i_block;
                        r_v     <= r_h;
                        r_round <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_round <= r_round + 7'd1;
                    if (r_round == 7'(ROUND_COUNT - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/sha512_stream_hasher.sv @@
// Top level: streaming SHA-512 hasher with padding and digest output.
// A word that fills a block starts its compression, and input is held off until the core is done.
// The last item pads with one or two blocks, writing the padding words one at a time,
// and then emits eight digest items, one per cycle as the sink takes them.
// Throughput is set by the single round unit: one round per cycle, 80 per block.
// Synchronous active-low reset restores the initial hash and clears all counters.
module sha512_stream_hasher (
    input  logic i_clk,
    input  logic i_rst_n,
    sha512_stream_if.sink   s_in,
    sha512_stream_if.source m_out
);
    import sha512_pkg::*;

    typedef enum logic [2:0] {S_IN, S_PAD, S_LEN, S_RUN, S_WAIT, S_OUT} t_state;

    t_state      r_state;
    t_word       r_buf [16];
    logic [3:0]  r_fill;
    logic [127:0] r_bits;
    logic        r_pad_pending;
    logic        r_final;
    logic [2:0]  r_idx;
    logic        r_start;
    logic        r_init;
    t_state      r_after;
    logic        core_busy;
    t_word       core_hash [8];

    t_word       in_word;
    logic [3:0]  in_cnt;
    logic        in_last;
    t_word       mask;
    t_word       padded;

    assign in_word = s_in.data.message_word;
    assign in_last = s_in.data.last_item;
    assign in_cnt  = (s_in.data.valid_bytes > FULL_BYTES) ? FULL_BYTES : s_in.data.valid_bytes;
    assign mask    = (in_cnt == 4'd0) ? '0 : ~(64'hFFFFFFFFFFFFFFFF >> {in_cnt, 3'b000});
    assign padded  = (in_word & mask) | (PAD_WORD >> {in_cnt, 3'b000});

    sha512_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_init  (r_init),
        .i_block (r_buf),
        .o_busy  (core_busy),
        .o_hash  (core_hash)
    );

    assign s_in.ready  = (r_state == S_IN) && !r_start && !core_busy && !r_init;
    assign m_out.valid = (r_state == S_OUT);
    assign m_out.data.digest_word      = core_hash[r_idx];
    assign m_out.data.digest_index     = r_idx;
    assign m_out.data.last_digest_word = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_fill  <= '0;
            r_bits  <= '0;
            r_pad_pending <= 1'b0;
            r_final <= 1'b0;
            r_idx   <= '0;
            r_start <= 1'b0;
            r_init  <= 1'b0;
            r_after <= S_IN;
        end else begin
            r_start <= 1'b0;
            r_init  <= 1'b0;
            unique case (r_state)
                S_IN: begin
                    if (s_in.valid && s_in.ready) begin
                        r_buf[r_fill] <= in_last && in_cnt != FULL_BYTES ? padded : in_word;
                        r_fill <= r_fill + 4'd1;
                        if (!in_last) begin
                            r_bits <= r_bits + 128'd64;
                            if (r_fill == 4'd15) begin
                                r_start <= 1'b1;
                                r_after <= S_IN;
                                r_state <= S_RUN;
                            end
                        end else begin
                            r_bits <= r_bits + 128'({in_cnt, 3'b000});
                            r_pad_pending <= (in_cnt == FULL_BYTES);
                            if (r_fill == 4'd15) begin
                                r_start <= 1'b1;
                                r_after <= S_PAD;
                                r_state <= S_RUN;
                            end else begin
                                r_state <= S_PAD;
                            end
                        end
                    end
                end
                S_PAD: begin
                    if (!r_pad_pending && r_fill == LENGTH_SLOT) begin
                        r_state <= S_LEN;
                    end else begin
                        if (r_pad_pending) begin
                            r_buf[r_fill] <= PAD_WORD;
                            r_pad_pending <= 1'b0;
                        end else begin
                            r_buf[r_fill] <= '0;
                        end
                        r_fill <= r_fill + 4'd1;
                        if (r_fill == 4'd15) begin
                            r_start <= 1'b1;
                            r_after <= S_PAD;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_LEN: begin
                    r_buf[14] <= r_bits[127:64];
                    r_buf[15] <= r_bits[63:0];
                    r_fill  <= '0;
                    r_final <= 1'b1;
                    r_start <= 1'b1;
                    r_after <= S_OUT;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!core_busy) begin
                        r_state <= r_after;
                        r_idx   <= '0;
                    end
                end
                S_OUT: begin
                    if (m_out.ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_state <= S_IN;
                            r_init  <= 1'b1;
                            r_bits  <= '0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IN;
            endcase
        end
    end

    a_out_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> r_final) else $error("digest output outside final block");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_busy |-> !s_in.ready) else $error("input accepted during compression");
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.ready && r_idx == 3'd7) |=> (r_fill == 4'd0 && r_bits == '0))
        else $error("state not cleared after digest");
endmodule
